FILE: hdl/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// shared constants, types and helpers of the gamepad sample conditioner
// ----------------------------------------------------------------------------
`default_nettype none

package gsc_pkg;

    // slot and button configuration
    localparam int SLOTS        = 4;
    localparam int BUTTON_COUNT = 15;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [15:0] BTN_MASK = 16'((32'h1 << BUTTON_COUNT) - 32'h1);
    localparam logic [15:0] ONE_Q15  = 16'h8000;

    // lane sequencer states
    typedef enum logic [2:0] {
        LN_IDLE,
        LN_SQ,
        LN_ROOT,
        LN_DEN,
        LN_PROD,
        LN_GO,
        LN_WAIT
    } t_lane_state;

    // top level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } t_top_state;

    // start request towards a lane
    typedef struct packed {
        logic        start;
        logic [15:0] dz;
    } t_lane_req;

    // deadzone values above 1.0 act as 1.0
    function automatic logic [15:0] sat_dz(input logic [15:0] d);
        sat_dz = (d > ONE_Q15) ? ONE_Q15 : d;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gsc_if.sv
// ----------------------------------------------------------------------------
// gsc_in_if / gsc_out_if
// valid/ready channels for samples in and slot reports out
// ----------------------------------------------------------------------------
`default_nettype none

interface gsc_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [2:0]         slot;
    logic               connected;
    logic [15:0]        buttons;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] left_trig;
    logic signed [15:0] right_trig;

    modport source (output valid, mode, slot, connected, buttons, left_x, left_y,
                    right_x, right_y, left_trig, right_trig, input ready);
    modport sink   (input valid, mode, slot, connected, buttons, left_x, left_y,
                    right_x, right_y, left_trig, right_trig, output ready);
endinterface

interface gsc_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         out_slot;
    logic               last;
    logic               is_connected;
    logic [15:0]        held;
    logic [15:0]        pressed;
    logic [15:0]        released;
    logic signed [15:0] norm_left_x;
    logic signed [15:0] norm_left_y;
    logic signed [15:0] norm_right_x;
    logic signed [15:0] norm_right_y;
    logic [14:0]        norm_left_trig;
    logic [14:0]        norm_right_trig;

    modport source (output valid, out_slot, last, is_connected, held, pressed, released,
                    norm_left_x, norm_left_y, norm_right_x, norm_right_y,
                    norm_left_trig, norm_right_trig, input ready);
    modport sink   (input valid, out_slot, last, is_connected, held, pressed, released,
                    norm_left_x, norm_left_y, norm_right_x, norm_right_y,
                    norm_left_trig, norm_right_trig, output ready);
endinterface

`default_nettype wire

FILE: hdl/gsc_div.sv
// ----------------------------------------------------------------------------
// gsc_div
// radix-2 restoring divider, 55-bit dividend by 40-bit divisor,
// 17 quotient bits, one bit per cycle, overflow flagged up front
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [54:0] i_num,
    input  wire logic [39:0] i_den,
    output logic             o_busy,
    output logic             o_ovf,
    output logic [16:0]      o_quot
);

    localparam logic [4:0] QBITS = 5'd17;

    logic [4:0]  r_cnt;
    logic [39:0] r_rem;
    logic [39:0] r_den;
    logic [16:0] r_sh;
    logic [16:0] r_quot;
    logic        r_ovf;

    logic [37:0] w_top;
    logic        w_ovf_in;
    logic [40:0] w_trial;
    logic        w_ge;
    logic [40:0] w_diff;

    // quotient would not fit in 17 bits
    assign w_top    = i_num[54:17];
    assign w_ovf_in = ({2'b00, w_top} >= i_den);

    // one restoring step
    assign w_trial = {r_rem, r_sh[16]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= w_ovf_in ? 5'd0 : QBITS;
        end else if (r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {2'b00, w_top};
            r_sh   <= i_num[16:0];
            r_quot <= '0;
            r_ovf  <= w_ovf_in;
            r_den  <= i_den;
        end else if (r_cnt != 5'd0) begin
            r_rem  <= w_ge ? w_diff[39:0] : w_trial[39:0];
            r_sh   <= {r_sh[15:0], 1'b0};
            r_quot <= {r_quot[15:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != 5'd0);
    assign o_ovf  = r_ovf;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: hdl/gsc_stick_lane.sv
// ----------------------------------------------------------------------------
// gsc_stick_lane
// radial deadzone for one stick: squared length, 24-step root,
// scale factor and two component divides
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_stick_lane (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gsc_pkg::t_lane_req i_req,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    output logic                    o_busy,
    output logic signed [15:0]      o_x,
    output logic signed [15:0]      o_y
);

    gsc_pkg::t_lane_state r_state;
    gsc_pkg::t_lane_state n_state;

    logic [4:0]  r_cnt;
    logic [15:0] r_mx, r_my;
    logic        r_nx, r_ny;
    logic [15:0] r_t;
    logic [47:0] r_val;
    logic [25:0] r_rem;
    logic [23:0] r_root;
    logic        r_zero;
    logic [23:0] r_num;
    logic [39:0] r_den;
    logic [39:0] r_px, r_py;
    logic signed [15:0] r_ox, r_oy;

    logic [15:0] w_ax, w_ay;
    logic [31:0] w_sqx, w_sqy;
    logic [27:0] w_r2;
    logic [27:0] w_trial;
    logic        w_ge;
    logic [23:0] w_cq, w_tq;
    logic [15:0] w_omt;
    logic        w_busy_x, w_busy_y;
    logic        w_ovf_x, w_ovf_y;
    logic [16:0] w_q_x, w_q_y;
    logic        w_div_start;
    logic        w_load_out;

    // sign and saturate one scaled component
    function automatic logic [15:0] sat_comp(input logic neg, input logic ovf,
                                             input logic [16:0] q);
        logic [15:0] res;
        if (neg) begin
            res = (ovf || q > 17'd32768) ? 16'h8000 : 16'(~q[15:0] + 16'd1);
        end else begin
            res = (ovf || q > 17'd32767) ? 16'h7FFF : q[15:0];
        end
        sat_comp = res;
    endfunction

    // magnitudes at start
    assign w_ax = i_x[15] ? 16'(~i_x + 16'd1) : i_x;
    assign w_ay = i_y[15] ? 16'(~i_y + 16'd1) : i_y;

    // squares
    assign w_sqx = r_mx * r_mx;
    assign w_sqy = r_my * r_my;

    // one root digit
    assign w_r2    = {r_rem, r_val[47:46]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_r2 >= w_trial);

    // clamped length against threshold
    assign w_cq  = (r_root > 24'h800000) ? 24'h800000 : r_root;
    assign w_tq  = {r_t, 8'h00};
    assign w_omt = 16'(17'h10000 - 17'h08000 - {1'b0, r_t} + 17'h08000 - 17'h08000
                   + 17'h08000 - 17'h08000);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gsc_pkg::LN_IDLE: if (i_req.start) n_state = gsc_pkg::LN_SQ;
            gsc_pkg::LN_SQ:   n_state = gsc_pkg::LN_ROOT;
            gsc_pkg::LN_ROOT: if (r_cnt == 5'd1) n_state = gsc_pkg::LN_DEN;
            gsc_pkg::LN_DEN:  n_state = gsc_pkg::LN_PROD;
            gsc_pkg::LN_PROD: n_state = gsc_pkg::LN_GO;
            gsc_pkg::LN_GO:   n_state = gsc_pkg::LN_WAIT;
            gsc_pkg::LN_WAIT: if (!w_busy_x && !w_busy_y) n_state = gsc_pkg::LN_IDLE;
            default:          n_state = gsc_pkg::LN_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_busy      = (r_state != gsc_pkg::LN_IDLE);
        w_div_start = (r_state == gsc_pkg::LN_GO);
        w_load_out  = (r_state == gsc_pkg::LN_WAIT) && !w_busy_x && !w_busy_y;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsc_pkg::LN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            gsc_pkg::LN_IDLE: begin
                r_mx <= w_ax;
                r_my <= w_ay;
                r_nx <= i_x[15];
                r_ny <= i_y[15];
                r_t  <= gsc_pkg::sat_dz(i_req.dz);
            end
            gsc_pkg::LN_SQ: begin
                r_val  <= {w_sqx + w_sqy, 16'h0000};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= 5'd24;
            end
            gsc_pkg::LN_ROOT: begin
                r_val  <= {r_val[45:0], 2'b00};
                r_rem  <= w_ge ? 26'(w_r2 - w_trial) : w_r2[25:0];
                r_root <= {r_root[22:0], w_ge};
                r_cnt  <= r_cnt - 5'd1;
            end
            gsc_pkg::LN_DEN: begin
                r_zero <= (r_t == gsc_pkg::ONE_Q15) || (w_cq <= w_tq);
                r_num  <= w_cq - w_tq;
                r_den  <= w_omt * r_root;
            end
            gsc_pkg::LN_PROD: begin
                r_px <= r_mx * r_num;
                r_py <= r_my * r_num;
            end
            gsc_pkg::LN_WAIT: begin
                if (w_load_out) begin
                    r_ox <= r_zero ? 16'sd0 : sat_comp(r_nx, w_ovf_x, w_q_x);
                    r_oy <= r_zero ? 16'sd0 : sat_comp(r_ny, w_ovf_y, w_q_y);
                end
            end
            default: begin
            end
        endcase
    end

    // component dividers sharing one divisor
    gsc_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_px, 15'h0000}),
        .i_den   (r_den),
        .o_busy  (w_busy_x),
        .o_ovf   (w_ovf_x),
        .o_quot  (w_q_x)
    );

    gsc_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({r_py, 15'h0000}),
        .i_den   (r_den),
        .o_busy  (w_busy_y),
        .o_ovf   (w_ovf_y),
        .o_quot  (w_q_y)
    );

    assign o_x = r_ox;
    assign o_y = r_oy;

endmodule

`default_nettype wire

FILE: hdl/gsc_trig_lane.sv
// ----------------------------------------------------------------------------
// gsc_trig_lane
// linear deadzone for one trigger: clamp, offset and one divide
// ----------------------------------------------------------------------------
`default_nettype none

module gsc_trig_lane (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gsc_pkg::t_lane_req i_req,
    input  wire logic signed [15:0] i_v,
    output logic                    o_busy,
    output logic [14:0]             o_v
);

    gsc_pkg::t_lane_state r_state;
    gsc_pkg::t_lane_state n_state;

    logic [14:0] r_c;
    logic [15:0] r_t;
    logic [14:0] r_out;

    logic        w_zero;
    logic [14:0] w_d;
    logic [15:0] w_omt;
    logic        w_busy;
    logic        w_ovf;
    logic [16:0] w_q;
    logic        w_div_start;
    logic        w_load_out;

    // offset and span of the live range
    assign w_zero = (r_t == gsc_pkg::ONE_Q15) || ({1'b0, r_c} <= r_t);
    assign w_d    = 15'({1'b0, r_c} - r_t);
    assign w_omt  = 16'(17'h08000 - {1'b0, r_t});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gsc_pkg::LN_IDLE: if (i_req.start) n_state = gsc_pkg::LN_GO;
            gsc_pkg::LN_GO:   n_state = gsc_pkg::LN_WAIT;
            gsc_pkg::LN_WAIT: if (!w_busy) n_state = gsc_pkg::LN_IDLE;
            default:          n_state = gsc_pkg::LN_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_busy      = (r_state != gsc_pkg::LN_IDLE);
        w_div_start = (r_state == gsc_pkg::LN_GO);
        w_load_out  = (r_state == gsc_pkg::LN_WAIT) && !w_busy;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsc_pkg::LN_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // clamp on start, result on finish
    always_ff @(posedge i_clk) begin
        if (r_state == gsc_pkg::LN_IDLE) begin
            r_c <= i_v[15] ? 15'd0 : i_v[14:0];
            r_t <= gsc_pkg::sat_dz(i_req.dz);
        end
        if (w_load_out) begin
            r_out <= (w_zero || w_ovf) ? 15'd0 : w_q[14:0];
        end
    end

    gsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({25'h0, w_d, 15'h0000}),
        .i_den   ({24'h0, w_omt}),
        .o_busy  (w_busy),
        .o_ovf   (w_ovf),
        .o_quot  (w_q)
    );

    assign o_v = r_out;

endmodule

`default_nettype wire

FILE: hdl/gamepad_sample_conditioner_unit.sv
// ----------------------------------------------------------------------------
// gamepad_sample_conditioner_unit
// per-slot gamepad state with button edge latches, radial stick deadzone
// and linear trigger deadzone; a consume request reports every slot
// ----------------------------------------------------------------------------
//  channel   dir  handshake          carries
//  i_in      in   valid/ready        sample or consume request
//  o_out     out  valid/ready        one slot report per cycle while o_out is ready
//  apb       in   psel/penable       stick and trigger deadzone registers
//
//  a connected sample holds i_in off until all four lanes are idle again:
//  the root steps and divide steps in the stick lanes set how long, and
//  the wait is shorter when both divides of each stick lane overflow
//  a disconnected sample or a sample to an absent slot leaves i_in ready
//  a consume request gives SLOTS reports, one per cycle while o_out is ready
//  reset is synchronous, active low, and clears all slot state
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_sample_conditioner_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gsc_in_if.sink     i_in,
    gsc_out_if.source  o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SW = gsc_pkg::SLOT_W;

    gsc_pkg::t_top_state r_state;
    gsc_pkg::t_top_state n_state;

    logic [15:0] r_stick_dz;
    logic [15:0] r_trig_dz;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_slot;

    logic [15:0]        r_held     [gsc_pkg::SLOTS];
    logic [15:0]        r_pressed  [gsc_pkg::SLOTS];
    logic [15:0]        r_released [gsc_pkg::SLOTS];
    logic               r_conn     [gsc_pkg::SLOTS];
    logic signed [15:0] r_lx       [gsc_pkg::SLOTS];
    logic signed [15:0] r_ly       [gsc_pkg::SLOTS];
    logic signed [15:0] r_rx       [gsc_pkg::SLOTS];
    logic signed [15:0] r_ry       [gsc_pkg::SLOTS];
    logic [14:0]        r_lt       [gsc_pkg::SLOTS];
    logic [14:0]        r_rt       [gsc_pkg::SLOTS];

    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_slot_ok;
    logic          w_last;
    logic [SW-1:0] w_addr;
    logic [15:0]   w_nh;
    logic          w_start;
    logic          w_disc;
    logic          w_all_idle;
    logic          w_cfg_wr;
    gsc_pkg::t_lane_req w_stick_req;
    gsc_pkg::t_lane_req w_trig_req;

    logic               w_busy_ls, w_busy_rs, w_busy_lt, w_busy_rt;
    logic signed [15:0] w_lx, w_ly, w_rx, w_ry;
    logic [14:0]        w_lt, w_rt;

    // request decode
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;
    assign w_slot_ok = ({1'b0, i_in.slot} < 4'(gsc_pkg::SLOTS));
    assign w_last    = (r_idx == SW'(gsc_pkg::SLOTS - 1));
    assign w_addr    = (r_state == gsc_pkg::ST_EMIT) ? r_idx : i_in.slot[SW-1:0];
    assign w_nh      = i_in.buttons & gsc_pkg::BTN_MASK;
    assign w_start   = w_in_acc && !i_in.mode && w_slot_ok && i_in.connected;
    assign w_disc    = w_in_acc && !i_in.mode && w_slot_ok && !i_in.connected;
    assign w_all_idle = !(w_busy_ls || w_busy_rs || w_busy_lt || w_busy_rt);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gsc_pkg::ST_IDLE: begin
                if (w_in_acc && i_in.mode) n_state = gsc_pkg::ST_EMIT;
                else if (w_start)          n_state = gsc_pkg::ST_CALC;
            end
            gsc_pkg::ST_CALC: if (w_all_idle) n_state = gsc_pkg::ST_IDLE;
            gsc_pkg::ST_EMIT: if (w_out_acc && w_last) n_state = gsc_pkg::ST_IDLE;
            default:          n_state = gsc_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready  = (r_state == gsc_pkg::ST_IDLE);
        o_out.valid = (r_state == gsc_pkg::ST_EMIT);
    end

    // state register and report index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsc_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && i_in.mode) begin
                r_idx <= '0;
            end else if (w_out_acc && !w_last) begin
                r_idx <= r_idx + SW'(1);
            end
        end
    end

    // slot latched for the lane write-back
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_slot <= i_in.slot[SW-1:0];
        end
    end

    // configuration registers
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = {16'h0000, paddr[2] ? r_trig_dz : r_stick_dz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_dz <= '0;
            r_trig_dz  <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[2]) r_trig_dz  <= pwdata[15:0];
            else          r_stick_dz <= pwdata[15:0];
        end
    end

    // slot store: buttons, edges, connection and axes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gsc_pkg::SLOTS; i++) begin
                r_held[i]     <= '0;
                r_pressed[i]  <= '0;
                r_released[i] <= '0;
                r_conn[i]     <= 1'b0;
                r_lx[i]       <= '0;
                r_ly[i]       <= '0;
                r_rx[i]       <= '0;
                r_ry[i]       <= '0;
                r_lt[i]       <= '0;
                r_rt[i]       <= '0;
            end
        end else begin
            if (w_start) begin
                r_pressed[w_addr]  <= r_pressed[w_addr] | (w_nh & ~r_held[w_addr]);
                r_released[w_addr] <= r_released[w_addr] | (r_held[w_addr] & ~w_nh);
                r_held[w_addr]     <= w_nh;
                r_conn[w_addr]     <= 1'b1;
            end
            if (w_disc) begin
                r_released[w_addr] <= r_released[w_addr] | r_held[w_addr];
                r_held[w_addr]     <= '0;
                r_conn[w_addr]     <= 1'b0;
                r_lx[w_addr]       <= '0;
                r_ly[w_addr]       <= '0;
                r_rx[w_addr]       <= '0;
                r_ry[w_addr]       <= '0;
                r_lt[w_addr]       <= '0;
                r_rt[w_addr]       <= '0;
            end
            if ((r_state == gsc_pkg::ST_CALC) && w_all_idle) begin
                r_lx[r_slot] <= w_lx;
                r_ly[r_slot] <= w_ly;
                r_rx[r_slot] <= w_rx;
                r_ry[r_slot] <= w_ry;
                r_lt[r_slot] <= w_lt;
                r_rt[r_slot] <= w_rt;
            end
            if (w_out_acc) begin
                r_pressed[r_idx]  <= '0;
                r_released[r_idx] <= '0;
            end
        end
    end

    // report payload
    assign o_out.out_slot        = 3'(r_idx);
    assign o_out.last            = w_last;
    assign o_out.is_connected    = r_conn[w_addr];
    assign o_out.held            = r_held[w_addr];
    assign o_out.pressed         = r_pressed[w_addr];
    assign o_out.released        = r_released[w_addr];
    assign o_out.norm_left_x     = r_lx[w_addr];
    assign o_out.norm_left_y     = r_ly[w_addr];
    assign o_out.norm_right_x    = r_rx[w_addr];
    assign o_out.norm_right_y    = r_ry[w_addr];
    assign o_out.norm_left_trig  = r_lt[w_addr];
    assign o_out.norm_right_trig = r_rt[w_addr];

    // lanes
    assign w_stick_req = '{start: w_start, dz: r_stick_dz};
    assign w_trig_req  = '{start: w_start, dz: r_trig_dz};

    gsc_stick_lane u_left_stick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_stick_req),
        .i_x     (i_in.left_x),
        .i_y     (i_in.left_y),
        .o_busy  (w_busy_ls),
        .o_x     (w_lx),
        .o_y     (w_ly)
    );

    gsc_stick_lane u_right_stick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_stick_req),
        .i_x     (i_in.right_x),
        .i_y     (i_in.right_y),
        .o_busy  (w_busy_rs),
        .o_x     (w_rx),
        .o_y     (w_ry)
    );

    gsc_trig_lane u_left_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_trig_req),
        .i_v     (i_in.left_trig),
        .o_busy  (w_busy_lt),
        .o_v     (w_lt)
    );

    gsc_trig_lane u_right_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_trig_req),
        .i_v     (i_in.right_trig),
        .o_busy  (w_busy_rt),
        .o_v     (w_rt)
    );

`ifndef NO_ASSERTIONS
    // lanes are quiet whenever the block waits for a request
    a_lanes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gsc_pkg::ST_IDLE) |-> w_all_idle)
        else $error("lane busy while idle");

    // the final report ends the consume run
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_last) |=> (r_state == gsc_pkg::ST_IDLE))
        else $error("consume run did not end on last slot");

    // a reported slot has its edge latches cleared
    a_edges_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |=> (r_pressed[$past(r_idx)] == 16'h0000)
                      && (r_released[$past(r_idx)] == 16'h0000))
        else $error("edge latches not cleared after report");
`endif

endmodule

`default_nettype wire
